FILE: sv/c2a_pkg.sv
// Shared constants, types and the restoring divide step for the color-to-alpha core.
`default_nettype none
package c2a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int CH_W      = 8;
  localparam int CFG_W     = Q_W;

  localparam logic [Q_W-1:0]  ONE     = Q_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0] CH_MAX  = {CH_W{1'b1}};

  typedef enum logic [1:0] {
    CFG_BG_RED   = 2'd0,
    CFG_BG_GREEN = 2'd1,
    CFG_BG_BLUE  = 2'd2,
    CFG_THRESH   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic            zero;
  } tail_t;

  // One restoring step: shift the remainder left, subtract the divisor if it fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [Q_W:0] div_step(input logic [Q_W-1:0] rem,
                                            input logic [Q_W-1:0] den);
    logic [Q_W:0] r2;
    logic [Q_W:0] diff;
    begin
      r2   = {rem, 1'b0};
      diff = r2 - {1'b0, den};
      if (r2 >= {1'b0, den}) begin
        div_step = {1'b1, diff[Q_W-1:0]};
      end else begin
        div_step = {1'b0, r2[Q_W-1:0]};
      end
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/c2a_fdiv.sv
// Pipelined fraction divider: quo = num * 2^FRAC_BITS / den, num <= den, one bit per stage.
`default_nettype none
module c2a_fdiv
  import c2a_pkg::*;
(
  input  logic           clk,
  input  logic [Q_W-1:0] num,
  input  logic [Q_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  logic [Q_W-1:0]       rem_r   [1:FRAC_BITS];
  logic [Q_W-1:0]       rem_nxt [1:FRAC_BITS];
  logic [Q_W-1:0]       den_r   [1:FRAC_BITS];
  logic [Q_W-1:0]       den_nxt [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] q_r     [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] q_nxt   [1:FRAC_BITS];
  logic                 full_r  [1:FRAC_BITS];
  logic                 full_nxt[1:FRAC_BITS];

  always_comb begin
    logic [Q_W:0] st;
    logic         full;
    full        = (num == den);
    st          = div_step(full ? '0 : num, den);
    rem_nxt[1]  = st[Q_W-1:0];
    den_nxt[1]  = den;
    q_nxt[1]    = {{(FRAC_BITS-1){1'b0}}, st[Q_W]};
    full_nxt[1] = full;
    for (int k = 2; k <= FRAC_BITS; k++) begin
      st          = div_step(rem_r[k-1], den_r[k-1]);
      rem_nxt[k]  = st[Q_W-1:0];
      den_nxt[k]  = den_r[k-1];
      q_nxt[k]    = {q_r[k-1][FRAC_BITS-2:0], st[Q_W]};
      full_nxt[k] = full_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= FRAC_BITS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      den_r[k]  <= den_nxt[k];
      q_r[k]    <= q_nxt[k];
      full_r[k] <= full_nxt[k];
    end
  end

  // equal operands give exactly one
  assign quo = full_r[FRAC_BITS] ? ONE : {1'b0, q_r[FRAC_BITS]};

endmodule
`default_nettype wire

FILE: sv/c2a_cdiv.sv
// Per-channel unblend: b + (c-b)*2^FRAC_BITS/a, truncated, saturated; one quotient bit per stage.
`default_nettype none
module c2a_cdiv
  import c2a_pkg::*;
(
  input  logic            clk,
  input  logic [Q_W-1:0]  fac,
  input  logic [CH_W-1:0] chan,
  input  logic [CH_W-1:0] bg,
  output logic [CH_W-1:0] res
);

  logic [Q_W-1:0]  rem_r   [1:CH_W];
  logic [Q_W-1:0]  rem_nxt [1:CH_W];
  logic [Q_W-1:0]  fac_r   [1:CH_W];
  logic [Q_W-1:0]  fac_nxt [1:CH_W];
  logic [CH_W-1:0] bg_r    [1:CH_W];
  logic [CH_W-1:0] bg_nxt  [1:CH_W];
  logic [CH_W-1:0] q_r     [1:CH_W];
  logic [CH_W-1:0] q_nxt   [1:CH_W];
  logic            neg_r   [1:CH_W];
  logic            neg_nxt [1:CH_W];
  logic            ovf_r   [1:CH_W];
  logic            ovf_nxt [1:CH_W];
  logic [CH_W-1:0] res_r;
  logic [CH_W-1:0] res_nxt;

  always_comb begin
    logic [Q_W:0]       st;
    logic               neg;
    logic [CH_W-1:0]    dd;
    logic [FRAC_BITS-1:0] rem0;
    neg        = (chan < bg);
    dd         = neg ? (bg - chan) : (chan - bg);
    rem0       = {dd, {(FRAC_BITS-CH_W){1'b0}}};
    // quotient of 2^CH_W or more saturates either way
    ovf_nxt[1] = ({1'b0, rem0} >= fac);
    st         = div_step({1'b0, rem0}, fac);
    rem_nxt[1] = st[Q_W-1:0];
    fac_nxt[1] = fac;
    bg_nxt[1]  = bg;
    neg_nxt[1] = neg;
    q_nxt[1]   = {{(CH_W-1){1'b0}}, st[Q_W]};
    for (int k = 2; k <= CH_W; k++) begin
      st         = div_step(rem_r[k-1], fac_r[k-1]);
      rem_nxt[k] = st[Q_W-1:0];
      fac_nxt[k] = fac_r[k-1];
      bg_nxt[k]  = bg_r[k-1];
      neg_nxt[k] = neg_r[k-1];
      ovf_nxt[k] = ovf_r[k-1];
      q_nxt[k]   = {q_r[k-1][CH_W-2:0], st[Q_W]};
    end
  end

  always_comb begin
    logic [CH_W:0] sum;
    sum = {1'b0, bg_r[CH_W]} + {1'b0, q_r[CH_W]};
    if (ovf_r[CH_W]) begin
      res_nxt = neg_r[CH_W] ? '0 : CH_MAX;
    end else if (neg_r[CH_W]) begin
      res_nxt = (q_r[CH_W] > bg_r[CH_W]) ? '0 : (bg_r[CH_W] - q_r[CH_W]);
    end else begin
      res_nxt = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= CH_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      fac_r[k] <= fac_nxt[k];
      bg_r[k]  <= bg_nxt[k];
      q_r[k]   <= q_nxt[k];
      neg_r[k] <= neg_nxt[k];
      ovf_r[k] <= ovf_nxt[k];
    end
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

FILE: sv/color_to_alpha_pixel_core.sv
// Top level of the color-to-alpha pixel core: config registers, pipeline control, datapath glue.
// Throughput: one word per clock; busy stays low, the pipeline never stalls.
// Depth is set by the two 16-stage fraction dividers (ratios, threshold scale)
// and the 8-stage unblend divider, one quotient bit per stage.
// Reset (synchronous, rst_n low) clears all valid bits and loads background 255/255/255
// and threshold 1.0; data registers are not reset.
`default_nettype none
module color_to_alpha_pixel_core
  import c2a_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic [CH_W-1:0]  in_alpha,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue,
  output logic [CH_W-1:0]  out_alpha,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // stage map: s0 input regs, s16 ratios, s17 max, s33 factor, s34 alpha,
  // s42 unblended channels, s43 output regs
  localparam int RATIO_ST = FRAC_BITS;
  localparam int MAX_ST   = RATIO_ST + 1;
  localparam int FAC_ST   = MAX_ST + FRAC_BITS;
  localparam int TAIL_ST  = FAC_ST + 1;
  localparam int LAST_ST  = FAC_ST + CH_W + 1;
  localparam int LATENCY  = LAST_ST + 2;

  // ---- configuration registers ----
  logic [CH_W-1:0] bg_red_r,   bg_red_nxt;
  logic [CH_W-1:0] bg_green_r, bg_green_nxt;
  logic [CH_W-1:0] bg_blue_r,  bg_blue_nxt;
  logic [Q_W-1:0]  thr_r,      thr_nxt;

  always_comb begin
    bg_red_nxt   = bg_red_r;
    bg_green_nxt = bg_green_r;
    bg_blue_nxt  = bg_blue_r;
    thr_nxt      = thr_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BG_RED:   bg_red_nxt   = cfg_data[CH_W-1:0];
        CFG_BG_GREEN: bg_green_nxt = cfg_data[CH_W-1:0];
        CFG_BG_BLUE:  bg_blue_nxt  = cfg_data[CH_W-1:0];
        CFG_THRESH:   thr_nxt      = (cfg_data > ONE) ? ONE : cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_red_r   <= CH_MAX;
      bg_green_r <= CH_MAX;
      bg_blue_r  <= CH_MAX;
      thr_r      <= ONE;
    end else begin
      bg_red_r   <= bg_red_nxt;
      bg_green_r <= bg_green_nxt;
      bg_blue_r  <= bg_blue_nxt;
      thr_r      <= thr_nxt;
    end
  end

  // ---- valid chain and pixel delay line ----
  logic            vld_r   [0:LAST_ST];
  logic            vld_nxt [0:LAST_ST];
  pix_t            pix_r   [0:LAST_ST];
  pix_t            pix_nxt [0:LAST_ST];
  tail_t           tail_r  [TAIL_ST:LAST_ST];
  tail_t           tail_nxt[TAIL_ST:LAST_ST];
  logic            out_valid_r;
  logic [CH_W-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [CH_W-1:0] out_red_nxt, out_green_nxt, out_blue_nxt, out_alpha_nxt;

  assign busy = 1'b0;

  always_comb begin
    vld_nxt[0] = start && !busy;
    pix_nxt[0] = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};
    for (int k = 1; k <= LAST_ST; k++) begin
      vld_nxt[k] = vld_r[k-1];
      pix_nxt[k] = pix_r[k-1];
    end
  end

  // ---- per-channel distance ratios: s0 -> s16 ----
  logic [CH_W-1:0] ch_c [0:2];
  logic [CH_W-1:0] ch_b [0:2];
  logic [Q_W-1:0]  rat_num [0:2];
  logic [Q_W-1:0]  rat_den [0:2];
  logic [Q_W-1:0]  ratio   [0:2];

  assign ch_c[0] = pix_r[0].red;
  assign ch_c[1] = pix_r[0].green;
  assign ch_c[2] = pix_r[0].blue;
  assign ch_b[0] = bg_red_r;
  assign ch_b[1] = bg_green_r;
  assign ch_b[2] = bg_blue_r;

  // above background: (c-b)/(255-b); below: (b-c)/b; equal: zero (divisor forced to 1)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ch_c[i] > ch_b[i]) begin
        rat_num[i] = {{(Q_W-CH_W){1'b0}}, ch_c[i] - ch_b[i]};
        rat_den[i] = {{(Q_W-CH_W){1'b0}}, CH_MAX - ch_b[i]};
      end else if (ch_c[i] < ch_b[i]) begin
        rat_num[i] = {{(Q_W-CH_W){1'b0}}, ch_b[i] - ch_c[i]};
        rat_den[i] = {{(Q_W-CH_W){1'b0}}, ch_b[i]};
      end else begin
        rat_num[i] = '0;
        rat_den[i] = Q_W'(1);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ratio
    c2a_fdiv u_ratio (
      .clk (clk),
      .num (rat_num[i]),
      .den (rat_den[i]),
      .quo (ratio[i])
    );
  end

  // ---- s17: largest ratio ----
  logic [Q_W-1:0] amax_r, amax_nxt;
  logic [Q_W-1:0] m01;

  always_comb begin
    m01      = (ratio[1] > ratio[0]) ? ratio[1] : ratio[0];
    amax_nxt = (ratio[2] > m01) ? ratio[2] : m01;
  end

  always_ff @(posedge clk) begin
    amax_r <= amax_nxt;
  end

  // ---- threshold scale: s17 -> s33 ----
  // below threshold: a/t; at or above: 1/1 gives one
  logic           below_thr;
  logic [Q_W-1:0] thr_num, thr_den, fac;

  assign below_thr = (amax_r < thr_r);
  assign thr_num   = below_thr ? amax_r : Q_W'(1);
  assign thr_den   = below_thr ? thr_r  : Q_W'(1);

  c2a_fdiv u_thr (
    .clk (clk),
    .num (thr_num),
    .den (thr_den),
    .quo (fac)
  );

  // ---- s34: alpha scale and zero-factor flag ----
  logic [Q_W+CH_W-1:0] alpha_prod;

  assign alpha_prod = fac * pix_r[FAC_ST].alpha;

  always_comb begin
    tail_nxt[TAIL_ST].alpha = alpha_prod[FRAC_BITS +: CH_W];
    tail_nxt[TAIL_ST].zero  = (fac == '0);
    for (int k = TAIL_ST + 1; k <= LAST_ST; k++) begin
      tail_nxt[k] = tail_r[k-1];
    end
  end

  // ---- unblend per channel: s33 -> s42 ----
  logic [CH_W-1:0] unb_red, unb_green, unb_blue;

  c2a_cdiv u_cdiv_r (
    .clk  (clk),
    .fac  (fac),
    .chan (pix_r[FAC_ST].red),
    .bg   (bg_red_r),
    .res  (unb_red)
  );

  c2a_cdiv u_cdiv_g (
    .clk  (clk),
    .fac  (fac),
    .chan (pix_r[FAC_ST].green),
    .bg   (bg_green_r),
    .res  (unb_green)
  );

  c2a_cdiv u_cdiv_b (
    .clk  (clk),
    .fac  (fac),
    .chan (pix_r[FAC_ST].blue),
    .bg   (bg_blue_r),
    .res  (unb_blue)
  );

  // ---- s43: output word; zero factor passes the color with alpha 0 ----
  always_comb begin
    if (tail_r[LAST_ST].zero) begin
      out_red_nxt   = pix_r[LAST_ST].red;
      out_green_nxt = pix_r[LAST_ST].green;
      out_blue_nxt  = pix_r[LAST_ST].blue;
      out_alpha_nxt = '0;
    end else begin
      out_red_nxt   = unb_red;
      out_green_nxt = unb_green;
      out_blue_nxt  = unb_blue;
      out_alpha_nxt = tail_r[LAST_ST].alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST_ST; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k <= LAST_ST; k++) begin
        vld_r[k] <= vld_nxt[k];
      end
      out_valid_r <= vld_r[LAST_ST];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST_ST; k++) begin
      pix_r[k] <= pix_nxt[k];
    end
    for (int k = TAIL_ST; k <= LAST_ST; k++) begin
      tail_r[k] <= tail_nxt[k];
    end
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_alpha_r <= out_alpha_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

  // ---- checks ----
  // every output word traces back to an accepted start
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("output word without matching start");

  // the opacity factor never exceeds one, so alpha can only shrink
  a_alpha_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha <= $past(in_alpha, LATENCY)))
    else $error("output alpha above input alpha");

  // threshold is held clamped to one
  a_thr_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    thr_r <= ONE)
    else $error("threshold register above one");

  // factor of one returns the pixel color unchanged (checked on the red channel)
  a_unity_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[FAC_ST] && fac == ONE) |-> ##(LAST_ST - FAC_ST + 1)
      (out_red == $past(pix_r[FAC_ST].red, LAST_ST - FAC_ST + 1)))
    else $error("unity factor changed red channel");

endmodule
`default_nettype wire

FILE: tb/sv/color_to_alpha_pixel_core_tb.sv
// Testbench for the color-to-alpha pixel core: directed and random pixels against a predictor.
`timescale 1ns / 1ps
module color_to_alpha_pixel_core_tb
  import c2a_pkg::*;
;

  localparam int LATENCY = 44;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [CH_W-1:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic             out_valid;
  logic [CH_W-1:0]  out_red, out_green, out_blue, out_alpha;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_BG_RED;
  logic [CFG_W-1:0] cfg_data = '0;

  color_to_alpha_pixel_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers
  int unsigned bg_r, bg_g, bg_b;
  longint      thr;

  pix_t expected_pix[$];
  int   mismatches = 0;

  function automatic longint dist_ratio(longint c, longint b);
    if (c > b) return ((c - b) * 65536) / (255 - b);
    if (c < b) return ((b - c) * 65536) / b;
    return 0;
  endfunction

  // SV '/' on signed longint truncates toward zero, as needed here
  function automatic logic [7:0] unblend(longint c, longint b, longint a);
    longint v;
    v = b + ((c - b) * 65536) / a;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic pix_t predict_pixel(pix_t p);
    longint a, m;
    pix_t   r;
    a = dist_ratio(p.red, bg_r);
    m = dist_ratio(p.green, bg_g); if (m > a) a = m;
    m = dist_ratio(p.blue, bg_b);  if (m > a) a = m;
    if (a < thr) a = (a * 65536) / thr;
    else a = 65536;
    if (a == 0) begin
      r = p;
      r.alpha = '0;
    end else begin
      r.red   = unblend(p.red, bg_r, a);
      r.green = unblend(p.green, bg_g, a);
      r.blue  = unblend(p.blue, bg_b, a);
      m = (a * p.alpha) >> 16;
      r.alpha = m[7:0];
    end
    return r;
  endfunction

  // register write; caller guarantees the pipe is drained
  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_BG_RED:   bg_r = val & 8'hFF;
      CFG_BG_GREEN: bg_g = val & 8'hFF;
      CFG_BG_BLUE:  bg_b = val & 8'hFF;
      CFG_THRESH:   thr = ((val & 17'h1FFFF) > 65536) ? 65536 : (val & 17'h1FFFF);
      default: ;
    endcase
  endtask

  task automatic set_bg_thr(int unsigned r, int unsigned g, int unsigned b, int unsigned t);
    write_reg(CFG_BG_RED, r);
    write_reg(CFG_BG_GREEN, g);
    write_reg(CFG_BG_BLUE, b);
    write_reg(CFG_THRESH, t);
  endtask

  // one word: start held at negedge until accepted on a rising edge
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pix_t p;
    p = {r, g, b, a};
    @(negedge clk);
    start = 1'b1; in_red = r; in_green = g; in_blue = b; in_alpha = a;
    do @(posedge clk); while (busy);
    expected_pix.push_back(predict_pixel(p));
    @(negedge clk);
    start = 1'b0;
  endtask

  // back-to-back burst: start stays high across words
  task automatic send_burst(int n);
    pix_t p;
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      p = $urandom;
      if ($urandom_range(0, 3) == 0) p.red = bg_r[7:0];
      if ($urandom_range(0, 3) == 0) p.green = bg_g[7:0];
      if ($urandom_range(0, 3) == 0) p.blue = bg_b[7:0];
      start = 1'b1; in_red = p.red; in_green = p.green; in_blue = p.blue; in_alpha = p.alpha;
      do @(posedge clk); while (busy);
      expected_pix.push_back(predict_pixel(p));
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    pix_t exp_p;
    if (rst_n && out_valid) begin
      if (expected_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h %h %h %h",
                                       out_red, out_green, out_blue, out_alpha);
      end else begin
        exp_p = expected_pix.pop_front();
        if (exp_p.red !== out_red || exp_p.green !== out_green ||
            exp_p.blue !== out_blue || exp_p.alpha !== out_alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp rgba %h %h %h %h got %h %h %h %h",
                     exp_p.red, exp_p.green, exp_p.blue, exp_p.alpha,
                     out_red, out_green, out_blue, out_alpha);
        end
      end
    end
  end

  task automatic test_reset_defaults;
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF); // pure background: zero factor
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
    send_pixel(8'h80, 8'h40, 8'hFF, 8'h7F);
    drain();
  endtask

  task automatic test_extremes;
    set_bg_thr(0, 0, 0, 65536);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h01, 8'h80);
    send_pixel(8'h01, 8'h01, 8'h01, 8'hFF);
    drain();
    set_bg_thr(128, 1, 254, 32768);
    send_pixel(8'h80, 8'h01, 8'hFE, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h81, 8'h00, 8'h00, 8'hAA);
    send_pixel(8'h7F, 8'h02, 8'hFD, 8'h55);
    drain();
  endtask

  task automatic test_threshold_cases;
    set_bg_thr(100, 150, 200, 0); // threshold zero: pass through
    send_pixel(8'h10, 8'h20, 8'h30, 8'h99);
    send_pixel(8'd100, 8'd150, 8'd200, 8'hFF);
    drain();
    set_bg_thr(100, 150, 200, 17'h1FFFF); // clamped to one
    send_pixel(8'h10, 8'h20, 8'h30, 8'h99);
    send_pixel(8'd101, 8'd150, 8'd200, 8'hFF);
    drain();
    set_bg_thr(100, 150, 200, 1);
    send_pixel(8'd101, 8'd150, 8'd200, 8'hFF);
    send_pixel(8'd100, 8'd150, 8'd200, 8'hFF);
    drain();
    // unknown index does not exist in a 2-bit enum; all four are covered
  endtask

  task automatic test_random;
    int sent;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_bg_thr(255, 255, 255, 65536);
        1: set_bg_thr(0, 0, 0, 0);
        2: set_bg_thr(0, 255, 0, 1);
        default: set_bg_thr($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 17'h1FFFF));
      endcase
      sent = 0;
      while (sent < 45) begin
        int n;
        n = $urandom_range(1, 12);
        send_burst(n);
        sent += n;
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      drain();
    end
  endtask

  initial begin
    bg_r = 255; bg_g = 255; bg_b = 255; thr = 65536;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_threshold_cases();
    test_random();
    if (mismatches == 0 && expected_pix.size() == 0) begin
      $display("PASS color_to_alpha_pixel_core");
    end else begin
      $display("FAIL color_to_alpha_pixel_core");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL color_to_alpha_pixel_core");
    $finish;
  end

endmodule
